>>> design/lz77_match_encoder_top_macros.svh
// assertion macros for the lz77 match encoder
`ifndef LZ77_MATCH_ENCODER_TOP_MACROS_SVH
`define LZ77_MATCH_ENCODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define LZME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define LZME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LZME_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZME_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/lzme_pkg.sv
// shared types and constants of the lz77 match encoder
package lzme_pkg;

    localparam int BYTE_W      = 8;
    localparam int DIST_W      = 4;
    localparam int LEN_W       = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MATCH,
        ST_SCAN,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    // per-cycle command to every cell of the history row
    typedef struct packed {
        logic load;       // copy history into the compare lane, restart the count
        logic step;       // compare against the broadcast lookahead byte
        logic shift_len;  // move match counts one cell toward distance 1
        logic push;       // shift one consumed byte into the history
        logic clear;      // drop the whole history at end of stream
    } t_cell_ctrl;

endpackage

>>> design/lzme_cell.sv
// one history cell: holds the byte at one distance and counts its match run
module lzme_cell
    import lzme_pkg::*;
#(
    parameter int LOOKAHEAD_SIZE = 8,
    parameter int IDX            = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cell_ctrl                        i_ctrl,
    input  logic [$clog2(LOOKAHEAD_SIZE)-1:0] i_k,
    input  logic [BYTE_W-1:0]                 i_look_byte,
    input  logic [BYTE_W-1:0]                 i_hist_byte,
    input  logic                              i_hval,
    input  logic [BYTE_W-1:0]                 i_cmp_byte,
    input  logic [$clog2(LOOKAHEAD_SIZE)-1:0] i_len,
    output logic [BYTE_W-1:0]                 o_hist_byte,
    output logic                              o_hval,
    output logic [BYTE_W-1:0]                 o_cmp_byte,
    output logic [$clog2(LOOKAHEAD_SIZE)-1:0] o_len
);

    localparam int LW = $clog2(LOOKAHEAD_SIZE);

    logic [BYTE_W-1:0] r_hist;
    logic              r_hval;
    logic [BYTE_W-1:0] r_cmp;
    logic              r_alive;
    logic [LW-1:0]     r_len;
    logic              w_hit;

    // a match at distance IDX+1 may not run past the newest history byte
    assign w_hit = r_alive && (32'(i_k) <= 32'(IDX)) && (r_cmp == i_look_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hval  <= 1'b0;
            r_alive <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_hval <= 1'b0;
            end else if (i_ctrl.push) begin
                r_hval <= i_hval;
            end
            if (i_ctrl.load) begin
                r_alive <= r_hval;
            end else if (i_ctrl.step) begin
                r_alive <= w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_hist <= i_hist_byte;
        end
        if (i_ctrl.load) begin
            r_cmp <= r_hist;
            r_len <= '0;
        end else if (i_ctrl.step) begin
            r_cmp <= i_cmp_byte;
            if (w_hit) begin
                r_len <= r_len + LW'(1);
            end
        end else if (i_ctrl.shift_len) begin
            r_len <= i_len;
        end
    end

    assign o_hist_byte = r_hist;
    assign o_hval      = r_hval;
    assign o_cmp_byte  = r_cmp;
    assign o_len       = r_len;

endmodule

>>> design/lz77_match_encoder_top.sv
// greedy lz77 encoder: lookahead buffer, sequencer and a row of history cells
//
//  channel  dir  fields (lowest bit up)
//  s_axis   in   tdata: data_byte[7:0]; tlast: end_of_stream
//  m_axis   out  tdata: distance[3:0], match_length[6:4], next_byte[14:7], 0 pad;
//                tuser: stream_done; tlast: last_of_run
//
// a byte that causes no token is only written into the lookahead buffer. a token
// is built in the states load, match, scan, shift and emit: the lookahead
// bytes are broadcast one a cycle to all cells, then the match counts walk
// down the cell row to the best-match tracker. no input is taken while a
// token is being built. reset empties both buffers; a waiting output item
// stalls the sequencer only at the point where a finished token is registered.
`include "lz77_match_encoder_top_macros.svh"

module lz77_match_encoder_top
    import lzme_pkg::*;
#(
    parameter int SEARCH_SIZE    = 8,
    parameter int LOOKAHEAD_SIZE = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // distance, match_length, next_byte, pad
    output logic                   m_axis_tuser,   // stream_done
    output logic                   m_axis_tlast
);

    localparam int KW   = $clog2(LOOKAHEAD_SIZE);
    localparam int LW   = $clog2(LOOKAHEAD_SIZE);
    localparam int FW   = $clog2(LOOKAHEAD_SIZE + 1);
    localparam int DC_W = $clog2(SEARCH_SIZE + 1);

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_look [LOOKAHEAD_SIZE];
    logic [FW-1:0]     r_fill;
    logic              r_eos;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_lim;
    logic [DC_W-1:0]   r_d;
    logic [LW-1:0]     r_best_len;
    logic [DC_W-1:0]   r_best_dist;
    logic [LW-1:0]     r_rem;

    logic              r_ovalid;
    logic [DIST_W-1:0] r_odist;
    logic [LEN_W-1:0]  r_olen;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_odone;
    logic              r_olast;

    t_cell_ctrl        w_ctrl;
    logic              w_in_acc;
    logic              w_emit_go;
    logic              w_final;
    logic [BYTE_W-1:0] w_bcast;

    logic [BYTE_W-1:0] w_hist_in  [SEARCH_SIZE];
    logic [BYTE_W-1:0] w_hist_out [SEARCH_SIZE];
    logic              w_hval_in  [SEARCH_SIZE];
    logic              w_hval_out [SEARCH_SIZE];
    logic [BYTE_W-1:0] w_cmp_in   [SEARCH_SIZE];
    logic [BYTE_W-1:0] w_cmp_out  [SEARCH_SIZE];
    logic [LW-1:0]     w_len_in   [SEARCH_SIZE];
    logic [LW-1:0]     w_len_out  [SEARCH_SIZE];

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_final   = r_eos && (r_fill == FW'(1));
    assign w_bcast   = r_look[r_k];

    // ---------------- history cell row ----------------
    for (genvar i = 0; i < SEARCH_SIZE; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_hist_in[i] = r_look[0];
            assign w_hval_in[i] = 1'b1;
            assign w_cmp_in[i]  = '0;
        end else begin : g_body
            assign w_hist_in[i] = w_hist_out[i-1];
            assign w_hval_in[i] = w_hval_out[i-1];
            assign w_cmp_in[i]  = w_cmp_out[i-1];
        end
        if (i == SEARCH_SIZE - 1) begin : g_tail
            assign w_len_in[i] = '0;
        end else begin : g_next
            assign w_len_in[i] = w_len_out[i+1];
        end

        lzme_cell #(
            .LOOKAHEAD_SIZE (LOOKAHEAD_SIZE),
            .IDX            (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_k         (r_k),
            .i_look_byte (w_bcast),
            .i_hist_byte (w_hist_in[i]),
            .i_hval      (w_hval_in[i]),
            .i_cmp_byte  (w_cmp_in[i]),
            .i_len       (w_len_in[i]),
            .o_hist_byte (w_hist_out[i]),
            .o_hval      (w_hval_out[i]),
            .o_cmp_byte  (w_cmp_out[i]),
            .o_len       (w_len_out[i])
        );
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (s_axis_tlast || (r_fill + FW'(1) == FW'(LOOKAHEAD_SIZE)))) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = (r_fill == FW'(1)) ? ST_SCAN : ST_MATCH;
            end
            ST_MATCH: begin
                if (r_k == r_lim - KW'(1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_d == DC_W'(SEARCH_SIZE)) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_rem == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit_go) begin
                    n_state = (r_eos && !w_final) ? ST_LOAD : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctrl        = '0;
        s_axis_tready = 1'b0;
        w_emit_go     = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready    = 1'b1;
            ST_LOAD:  w_ctrl.load      = 1'b1;
            ST_MATCH: w_ctrl.step      = 1'b1;
            ST_SCAN:  w_ctrl.shift_len = 1'b1;
            ST_SHIFT: w_ctrl.push      = (r_rem != '0);
            ST_EMIT: begin
                w_emit_go    = !r_ovalid || m_axis_tready;
                w_ctrl.push  = w_emit_go;
                w_ctrl.clear = w_emit_go && w_final;
            end
            default: w_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_eos    <= 1'b0;
            r_k      <= '0;
            r_d      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_fill <= r_fill + FW'(1);
                r_eos  <= s_axis_tlast;
            end else if (w_ctrl.push) begin
                r_fill <= r_fill - FW'(1);
            end
            if (w_ctrl.load) begin
                r_k <= '0;
                r_d <= DC_W'(1);
            end else if (w_ctrl.step) begin
                r_k <= r_k + KW'(1);
            end else if (w_ctrl.shift_len) begin
                r_d <= r_d + DC_W'(1);
            end
            if (w_emit_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // lookahead buffer, best-match tracker and output payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_look[r_fill[KW-1:0]] <= s_axis_tdata[BYTE_W-1:0];
        end else if (w_ctrl.push) begin
            for (int j = 0; j < LOOKAHEAD_SIZE - 1; j++) begin
                r_look[j] <= r_look[j+1];
            end
        end
        if (w_ctrl.load) begin
            r_lim       <= KW'(r_fill - FW'(1));
            r_best_len  <= '0;
            r_best_dist <= '0;
        end else if (w_ctrl.shift_len) begin
            // strict compare keeps the nearest distance on a tie
            if (w_len_out[0] > r_best_len) begin
                r_best_len  <= w_len_out[0];
                r_best_dist <= r_d;
            end
        end
        if (r_state == ST_SCAN && n_state == ST_SHIFT) begin
            r_rem <= (w_len_out[0] > r_best_len) ? w_len_out[0] : r_best_len;
        end else if (r_state == ST_SHIFT && r_rem != '0) begin
            r_rem <= r_rem - LW'(1);
        end
        if (w_emit_go) begin
            r_odist <= DIST_W'(r_best_dist);
            r_olen  <= LEN_W'(r_best_len);
            r_obyte <= r_look[0];
            r_odone <= w_final;
            r_olast <= !r_eos || w_final;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_obyte, r_olen, r_odist};
    assign m_axis_tuser  = r_odone;
    assign m_axis_tlast  = r_olast;

    // ---------------- checks ----------------
    `LZME_ASSERT(a_room_on_accept, i_clk, i_rst_n, s_axis_tready |-> (r_fill < FW'(LOOKAHEAD_SIZE)), "lookahead full while taking input")
    `LZME_ASSERT(a_done_is_last, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "stream end token not last of run")
    `LZME_ASSERT(a_flush_empties, i_clk, i_rst_n, (w_emit_go && w_final) |=> ((r_fill == '0) && (r_state == ST_IDLE)), "flush left lookahead bytes")
    `LZME_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

>>> tb/tb_lz77_match_encoder_top.sv
// testbench for the lz77 match encoder: random byte streams checked token by token
module tb_lz77_match_encoder_top
    import lzme_pkg::*;
();

    localparam int SEARCH_SIZE    = 8;
    localparam int LOOKAHEAD_SIZE = 8;
    localparam int RANDOM_ITEMS   = 420;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  match_length;
        logic [BYTE_W-1:0] next_byte;
        logic              stream_done;
        logic              last_of_run;
    } t_token;

    class lz77_token_model;
        logic [BYTE_W-1:0] history[SEARCH_SIZE];
        int                history_fill;
        logic [BYTE_W-1:0] lookahead[LOOKAHEAD_SIZE];
        int                lookahead_fill;
        t_token            awaited_tokens[$];
        int                mismatch_count;
        int                token_index;

        function new();
            foreach (history[k]) history[k] = '0;
            foreach (lookahead[k]) lookahead[k] = '0;
            history_fill   = 0;
            lookahead_fill = 0;
            mismatch_count = 0;
            token_index    = 0;
        endfunction

        function void push_history(logic [BYTE_W-1:0] b);
            for (int k = SEARCH_SIZE - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = b;
            if (history_fill < SEARCH_SIZE) history_fill++;
        endfunction

        // longest match, nearest distance on a tie, then consume match plus literal
        function t_token encode_next_token();
            t_token t;
            int best_len;
            int best_dist;
            int reach;
            int len;
            int used;
            best_len  = 0;
            best_dist = 0;
            reach     = lookahead_fill - 1;
            for (int d = 1; d <= history_fill; d++) begin
                len = 0;
                while (len < d && len < reach && history[d-1-len] == lookahead[len]) len++;
                if (len > best_len) begin
                    best_len  = len;
                    best_dist = d;
                end
            end
            t.distance     = best_dist[DIST_W-1:0];
            t.match_length = best_len[LEN_W-1:0];
            t.next_byte    = lookahead[best_len];
            t.stream_done  = 1'b0;
            t.last_of_run  = 1'b0;
            used = best_len + 1;
            for (int k = 0; k < used; k++) push_history(lookahead[k]);
            for (int k = 0; k + used < lookahead_fill; k++) lookahead[k] = lookahead[k+used];
            lookahead_fill -= used;
            return t;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic eos);
            t_token t;
            if (lookahead_fill < LOOKAHEAD_SIZE) begin
                lookahead[lookahead_fill] = b;
                lookahead_fill++;
            end
            if (eos) begin
                // flush everything; the final token closes both the run and the stream
                while (lookahead_fill > 0) begin
                    t = encode_next_token();
                    if (lookahead_fill == 0) begin
                        t.stream_done = 1'b1;
                        t.last_of_run = 1'b1;
                    end
                    awaited_tokens.push_back(t);
                end
                history_fill   = 0;
                lookahead_fill = 0;
            end else if (lookahead_fill == LOOKAHEAD_SIZE) begin
                t = encode_next_token();
                t.last_of_run = 1'b1;
                awaited_tokens.push_back(t);
            end
        endfunction

        function int pending();
            return awaited_tokens.size();
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("token %0d: %s", token_index, msg);
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
        endtask

        task check_token(t_token got);
            t_token want;
            if (awaited_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token dist %0d len %0d byte %02h",
                                          got.distance, got.match_length, got.next_byte));
            end else begin
                want = awaited_tokens.pop_front();
                compare_field("distance", 32'(got.distance), 32'(want.distance));
                compare_field("match_length", 32'(got.match_length), 32'(want.match_length));
                compare_field("next_byte", 32'(got.next_byte), 32'(want.next_byte));
                compare_field("stream_done", 32'(got.stream_done), 32'(want.stream_done));
                compare_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
            end
            token_index++;
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // data_byte[7:0]
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // distance, match_length, next_byte, pad
    logic                   m_axis_tuser;         // stream_done
    logic                   m_axis_tlast;

    lz77_token_model board = new();

    int tx_pct  = 0;
    int rx_pct  = 0;
    bit hold_req = 1'b0;

    lz77_match_encoder_top #(
        .SEARCH_SIZE   (SEARCH_SIZE),
        .LOOKAHEAD_SIZE(LOOKAHEAD_SIZE)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_token got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.distance     = m_axis_tdata[DIST_W-1:0];
                got.match_length = m_axis_tdata[DIST_W+LEN_W-1:DIST_W];
                got.next_byte    = m_axis_tdata[DIST_W+LEN_W+BYTE_W-1:DIST_W+LEN_W];
                got.stream_done  = m_axis_tuser;
                got.last_of_run  = m_axis_tlast;
                board.check_token(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_byte(b, eos);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // mostly repetitive content so that matches are common, some fully random
    task automatic send_stream(input int len);
        logic [7:0] alphabet[4];
        logic [7:0] motif[8];
        int         style;
        int         period;
        logic [7:0] b;
        style  = $urandom_range(0, 9);
        period = $urandom_range(1, 8);
        foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
        foreach (motif[k]) motif[k] = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            if (style <= 5)
                b = alphabet[$urandom_range(0, 3)];
            else if (style <= 7)
                b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : motif[i % period];
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    initial begin
        logic [7:0] motif7[7];
        int         sent;
        int         len;
        bit         held;
        bit         paused;
        motif7 = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80};
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte streams at both byte extremes, then a period-7 stream
        // that reaches the longest match at distance 7
        tx_pct = 15;
        rx_pct = 15;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 22; i++) send_byte(motif7[i % 7], i == 21);

        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS * 7 / 8) begin
                tx_pct = 0;
                rx_pct = 0;
            end else begin
                tx_pct = pick_pct();
                rx_pct = pick_pct();
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 24);
            if (!held && sent >= 100) begin
                // sender keeps offering while the receiver is held off
                held     = 1'b1;
                tx_pct   = 0;
                hold_req = 1'b1;
                len      = 40;
            end else if (!paused && sent >= 220) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            send_stream(len);
            sent += len;
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
